### hdl/png_color_chunk_injector_unit_defines.svh
// assertion macros for the png color chunk injector
// used by the top level only; no other dependencies
`ifndef PNG_COLOR_CHUNK_INJECTOR_UNIT_DEFINES_SVH
`define PNG_COLOR_CHUNK_INJECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// ante must imply cons in the same cycle
`define PCCI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcci assertion failed");
// cond must never hold
`define PCCI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pcci assertion failed");
`else
`define PCCI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PCCI_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

### hdl/pcci_pkg.sv
// shared types, constants and tables of the png color chunk injector
// no dependencies; used by every module of the block
package pcci_pkg;

  localparam int unsigned SIG_BYTES           = 8;
  localparam int unsigned HOLD_BYTES          = 11;
  localparam int unsigned HEAD_BYTES          = 12;
  localparam int unsigned COLOUR_BYTES        = 73;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_BYTES);
  localparam int unsigned BASE_W     = $clog2(HEAD_BYTES + 1);
  localparam int unsigned IDX_W      = $clog2(HEAD_BYTES + COLOUR_BYTES + 2);

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] KIND_IHDR = 32'h49484452;
  localparam logic [31:0] KIND_SRGB = 32'h73524742;
  localparam logic [31:0] KIND_GAMA = 32'h67414D41;
  localparam logic [31:0] KIND_CHRM = 32'h6348524D;
  localparam logic [31:0] GAMMA_VALUE = 32'd45455;
  localparam logic [31:0] CHRM_VALUES [8] = '{
    32'd31270, 32'd32900, 32'd64000, 32'd33000,
    32'd30000, 32'd60000, 32'd15000, 32'd6000
  };

  // fixed file signature, entry 0 goes out first
  localparam logic [SIG_BYTES-1:0][7:0] SIG_ROM = {
    8'd10, 8'd26, 8'd10, 8'd13, 8'd71, 8'd78, 8'd80, 8'd137
  };

  typedef logic [COLOUR_BYTES-1:0][7:0] colour_rom_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_pair;
    logic [1:0]  out_count;
    logic        out_last;
    logic        out_status;
  } out_item_t;

  // one classified input byte: base bytes, optional color chunks, end flags
  typedef struct packed {
    logic [HEAD_BYTES-1:0][7:0] bytes;
    logic [BASE_W-1:0]          base_len;
    logic                       insert;
    logic [IDX_W-1:0]           total;
    logic                       last;
    logic                       status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // big-endian word into the table at pos
  function automatic colour_rom_t put32(colour_rom_t r, int pos, logic [31:0] v);
    colour_rom_t t;
    t = r;
    for (int j = 0; j < 4; j++) begin
      t[pos + j] = v[31 - 8 * j -: 8];
    end
    return t;
  endfunction

  // reflected crc-32 over a span of the table
  function automatic logic [31:0] crc_of(colour_rom_t r, int start, int len);
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < len; i++) begin
      c = c ^ {24'd0, r[start + i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  // srgb, gama and chrm chunks, built at elaboration
  function automatic colour_rom_t build_colour_rom();
    colour_rom_t r;
    int          pos;
    int          start;
    r   = '0;
    pos = 0;
    // srgb
    r = put32(r, pos, 32'd1);          pos = pos + 4;
    start = pos;
    r = put32(r, pos, KIND_SRGB);      pos = pos + 4;
    r[pos] = 8'd0;                     pos = pos + 1;
    r = put32(r, pos, crc_of(r, start, pos - start));
    pos = pos + 4;
    // gama
    r = put32(r, pos, 32'd4);          pos = pos + 4;
    start = pos;
    r = put32(r, pos, KIND_GAMA);      pos = pos + 4;
    r = put32(r, pos, GAMMA_VALUE);    pos = pos + 4;
    r = put32(r, pos, crc_of(r, start, pos - start));
    pos = pos + 4;
    // chrm
    r = put32(r, pos, 32'd32);         pos = pos + 4;
    start = pos;
    r = put32(r, pos, KIND_CHRM);      pos = pos + 4;
    for (int i = 0; i < 8; i++) begin
      r = put32(r, pos, CHRM_VALUES[i]);
      pos = pos + 4;
    end
    r = put32(r, pos, crc_of(r, start, pos - start));
    return r;
  endfunction

  localparam colour_rom_t COLOUR_ROM = build_colour_rom();

endpackage

### hdl/pcci_front.sv
// front end: accepts file bytes, tracks signature and chunk walk, emits jobs
// depends on pcci_pkg
module pcci_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  pcci_pkg::in_item_t      byte_item,
  input  pcci_pkg::queue_status_t q_status,
  output logic                    q_push,
  output pcci_pkg::job_t          q_job
);
  import pcci_pkg::*;

  logic [3:0]  sig_count, sig_count_next;
  logic [32:0] chunk_pos, chunk_pos_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic [31:0] chunk_kind, chunk_kind_next;
  logic        inserted, inserted_next;
  logic [7:0]  held [HOLD_BYTES];
  logic        held_we;
  logic        accept;
  logic        chunk_end;
  logic        ins;
  job_t        job;

  assign byte_ready = !q_status.full;
  assign accept     = byte_valid && byte_ready;
  assign chunk_end  = (chunk_pos == ({1'b0, chunk_len} + 33'd11));

  // classify the byte and work out the next walk state
  always_comb begin
    sig_count_next  = sig_count;
    chunk_pos_next  = chunk_pos;
    chunk_len_next  = chunk_len;
    chunk_kind_next = chunk_kind;
    inserted_next   = inserted;
    held_we         = 1'b0;
    ins             = 1'b0;
    job             = '0;
    if (accept) begin
      if (sig_count < 4'(SIG_BYTES)) begin
        job.bytes[0] = SIG_ROM[sig_count[2:0]];
        job.base_len = BASE_W'(1);
        job.total    = IDX_W'(1);
        job.status   = byte_item.in_last;
        sig_count_next = sig_count + 4'd1;
      end else if (chunk_pos < 33'(HOLD_BYTES)) begin
        // header bytes are held back
        held_we        = 1'b1;
        chunk_pos_next = chunk_pos + 33'd1;
        if (chunk_pos < 33'd4) begin
          chunk_len_next = {chunk_len[23:0], byte_item.in_byte};
        end else if (chunk_pos < 33'd8) begin
          chunk_kind_next = {chunk_kind[23:0], byte_item.in_byte};
        end
      end else begin
        if (chunk_pos == 33'(HOLD_BYTES)) begin
          for (int j = 0; j < HOLD_BYTES; j++) begin
            job.bytes[j] = held[j];
          end
          job.bytes[HEAD_BYTES-1] = byte_item.in_byte;
          job.base_len = BASE_W'(HEAD_BYTES);
        end else begin
          job.bytes[0] = byte_item.in_byte;
          job.base_len = BASE_W'(1);
        end
        if (chunk_end) begin
          ins             = !inserted && (chunk_kind == KIND_IHDR);
          inserted_next   = inserted || ins;
          chunk_pos_next  = '0;
          chunk_len_next  = '0;
          chunk_kind_next = '0;
        end else begin
          chunk_pos_next = chunk_pos + 33'd1;
          job.status     = byte_item.in_last;
        end
        job.insert = ins;
        job.total  = IDX_W'(job.base_len) + (ins ? IDX_W'(COLOUR_BYTES) : IDX_W'(0));
      end
      job.last = byte_item.in_last;
      // end of file: start over
      if (byte_item.in_last) begin
        sig_count_next  = '0;
        chunk_pos_next  = '0;
        chunk_len_next  = '0;
        chunk_kind_next = '0;
        inserted_next   = 1'b0;
      end
    end
  end

  assign q_push = accept && ((job.total != '0) || byte_item.in_last);
  assign q_job  = job;

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_count  <= '0;
      chunk_pos  <= '0;
      chunk_len  <= '0;
      chunk_kind <= '0;
      inserted   <= 1'b0;
    end else begin
      sig_count  <= sig_count_next;
      chunk_pos  <= chunk_pos_next;
      chunk_len  <= chunk_len_next;
      chunk_kind <= chunk_kind_next;
      inserted   <= inserted_next;
    end
  end

  // held header bytes
  always_ff @(posedge clk) begin
    if (held_we) begin
      held[chunk_pos[HEAD_IDX_W-1:0]] <= byte_item.in_byte;
    end
  end

endmodule

### hdl/pcci_job_queue.sv
// short job queue between the front end and the back end
// depends on pcci_pkg
module pcci_job_queue #(
  parameter int unsigned DEPTH = pcci_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pcci_pkg::job_t          push_job,
  input  logic                    pop,
  output pcci_pkg::job_t          head,
  output pcci_pkg::queue_status_t status
);
  import pcci_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### hdl/pcci_back.sv
// back end: expands the head job into byte pairs through an output register
// depends on pcci_pkg
module pcci_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pcci_pkg::job_t          head,
  input  pcci_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    pair_valid,
  input  logic                    pair_ready,
  output pcci_pkg::out_item_t     pair_item
);
  import pcci_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] remaining;
  logic             fin;
  logic [1:0]       cnt;
  logic             load;
  out_item_t        next_item;

  // byte k of a job: base bytes, then the color chunks
  function automatic logic [7:0] pick(job_t j, logic [IDX_W-1:0] k);
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       v;
    r_idx = k - IDX_W'(j.base_len);
    if (k < IDX_W'(j.base_len)) begin
      v = j.bytes[k[HEAD_IDX_W-1:0]];
    end else if (r_idx < IDX_W'(COLOUR_BYTES)) begin
      v = COLOUR_ROM[r_idx];
    end else begin
      v = 8'd0;
    end
    return v;
  endfunction

  assign load      = !q_status.empty && (!pair_valid || pair_ready);
  assign remaining = head.total - idx;
  assign fin       = (remaining <= IDX_W'(2));
  assign cnt       = (remaining >= IDX_W'(2)) ? 2'd2 : remaining[1:0];
  assign pop       = load && fin;

  // next pair from the head job
  always_comb begin
    next_item            = '0;
    next_item.out_count  = cnt;
    if (cnt != 2'd0) begin
      next_item.out_pair[15:8] = pick(head, idx);
    end
    if (cnt == 2'd2) begin
      next_item.out_pair[7:0] = pick(head, idx + IDX_W'(1));
    end
    next_item.out_last   = fin && head.last;
    next_item.out_status = fin && head.last && head.status;
  end

  // output register and position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      pair_valid <= 1'b1;
      idx        <= fin ? '0 : idx + IDX_W'(2);
    end else if (pair_ready) begin
      pair_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair_item <= next_item;
    end
  end

endmodule

### hdl/png_color_chunk_injector_unit.sv
// throughput: one byte per cycle in, one result per cycle out while the
//   receiver is ready; a byte can cause up to 43 results (where the first
//   ihdr ends), the back end working through them in turn, and input stalls
//   once the job queue (QUEUE_DEPTH entries) is full
// reset: synchronous, clears walk state, queue and output valid; held bytes keep
`include "png_color_chunk_injector_unit_defines.svh"
module png_color_chunk_injector_unit #(
  parameter int unsigned QUEUE_DEPTH = pcci_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  pcci_pkg::in_item_t  byte_item,
  output logic                pair_valid,
  input  logic                pair_ready,
  output pcci_pkg::out_item_t pair_item
);
  import pcci_pkg::*;

  logic          q_push;
  logic          q_pop;
  job_t          q_job;
  job_t          q_head;
  queue_status_t q_status;
  logic          pair_no_bytes;

  // classify incoming bytes
  pcci_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  // decouple front and back
  pcci_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // produce byte pairs
  pcci_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_status   (q_status),
    .pop        (q_pop),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair_item  (pair_item)
  );

  assign pair_no_bytes = (pair_item.out_count == 2'd0);

  // checks
  `PCCI_ASSERT_NEVER(a_push_full, clk, rst, q_push && q_status.full)
  `PCCI_ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && q_status.empty)
  `PCCI_ASSERT_IMPLIES(a_empty_is_last, clk, rst, pair_valid && pair_no_bytes, pair_item.out_last)
  `PCCI_ASSERT_IMPLIES(a_status_on_last, clk, rst, pair_valid && pair_item.out_status, pair_item.out_last)

endmodule

### sim/pcci_stream_checker.sv
`timescale 1ns / 100ps
// checker for the png color chunk injector: watches both channels, predicts the
// paired byte stream of every accepted byte and compares it with the results
// depends on pcci_pkg for the input and result item types
module pcci_stream_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic                byte_ready,
  input  pcci_pkg::in_item_t  byte_item,
  input  logic                pair_valid,
  input  logic                pair_ready,
  input  pcci_pkg::out_item_t pair_item,
  output int                  failures,
  output int                  outstanding
);
  import pcci_pkg::*;

  localparam int          HEAD_HOLD     = 11;
  localparam logic [31:0] IHDR_TAG      = 32'h49484452;
  localparam logic [31:0] SRGB_TAG      = 32'h73524742;
  localparam logic [31:0] GAMA_TAG      = 32'h67414D41;
  localparam logic [31:0] CHRM_TAG      = 32'h6348524D;
  localparam logic [31:0] CRC_REFLECTED = 32'hEDB88320;
  localparam logic [31:0] GAMMA_X100K   = 32'd45455;
  localparam logic [0:7][7:0] FILE_SIGNATURE = {
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };
  localparam logic [0:7][31:0] CHROMA_POINTS = {
    32'd31270, 32'd32900, 32'd64000, 32'd33000,
    32'd30000, 32'd60000, 32'd15000, 32'd6000
  };

  // walk state of the predicted block
  logic [3:0]  sig_seen;
  logic [32:0] chunk_seen;
  logic [31:0] chunk_len;
  logic [31:0] chunk_tag;
  logic [7:0]  head_hold [HEAD_HOLD];
  logic        colour_sent;

  logic [7:0]  colour_block [$];
  logic [7:0]  emitted [$];
  out_item_t   expected_pairs [$];
  out_item_t   want;

  // append helpers for the queues
  task automatic append_colour(input logic [7:0] b);
    colour_block.insert(colour_block.size(), b);
  endtask

  task automatic append_emitted(input logic [7:0] b);
    emitted.insert(emitted.size(), b);
  endtask

  task automatic append_expected(input out_item_t e);
    expected_pairs.insert(expected_pairs.size(), e);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int j = 0; j < 4; j++) begin
      append_colour(w[31 - 8 * j -: 8]);
    end
  endtask

  // crc-32 over tag and data of a chunk already in the color block
  function automatic logic [31:0] crc_over(input int first, input int count);
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < count; i++) begin
      c = c ^ {24'd0, colour_block[first + i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_REFLECTED) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  // srgb, gama and chrm chunks that follow the first ihdr
  initial begin : build_colour_block
    int mark;
    push_word(32'd1);
    mark = colour_block.size();
    push_word(SRGB_TAG);
    append_colour(8'd0);
    push_word(crc_over(mark, colour_block.size() - mark));
    push_word(32'd4);
    mark = colour_block.size();
    push_word(GAMA_TAG);
    push_word(GAMMA_X100K);
    push_word(crc_over(mark, colour_block.size() - mark));
    push_word(32'd32);
    mark = colour_block.size();
    push_word(CHRM_TAG);
    for (int i = 0; i < 8; i++) begin
      push_word(CHROMA_POINTS[i]);
    end
    push_word(crc_over(mark, colour_block.size() - mark));
  end

  task automatic clear_walk();
    sig_seen    = '0;
    chunk_seen  = '0;
    chunk_len   = '0;
    chunk_tag   = '0;
    colour_sent = 1'b0;
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  // bytes caused by one input byte, packed two per result
  task automatic predict_pairs(input in_item_t it);
    logic      bad;
    int        nres;
    out_item_t res;
    emitted.delete();
    bad = 1'b0;
    if (sig_seen < 4'd8) begin
      // signature bytes are replaced
      append_emitted(FILE_SIGNATURE[sig_seen[2:0]]);
      sig_seen = sig_seen + 4'd1;
      bad = it.in_last;
    end else begin
      chunk_seen = chunk_seen + 33'd1;
      if (chunk_seen <= 33'd11) begin
        // chunk head held back, length and tag collected big-endian
        head_hold[int'(chunk_seen) - 1] = it.in_byte;
        if (chunk_seen <= 33'd4) begin
          chunk_len = {chunk_len[23:0], it.in_byte};
        end else if (chunk_seen <= 33'd8) begin
          chunk_tag = {chunk_tag[23:0], it.in_byte};
        end
      end else begin
        if (chunk_seen == 33'd12) begin
          for (int i = 0; i < HEAD_HOLD; i++) begin
            append_emitted(head_hold[i]);
          end
        end
        append_emitted(it.in_byte);
        if (chunk_seen == 33'd12 + {1'b0, chunk_len}) begin
          // chunk complete, color chunks after the first ihdr only
          if (!colour_sent && chunk_tag == IHDR_TAG) begin
            foreach (colour_block[i]) begin
              append_emitted(colour_block[i]);
            end
            colour_sent = 1'b1;
          end
          chunk_seen = '0;
          chunk_len  = '0;
          chunk_tag  = '0;
        end else begin
          bad = it.in_last;
        end
      end
    end
    nres = (emitted.size() + 1) / 2;
    if (it.in_last && nres == 0) begin
      nres = 1;
    end
    for (int r = 0; r < nres; r++) begin
      res = '0;
      if (2 * r < emitted.size()) begin
        res.out_pair[15:8] = emitted[2 * r];
        res.out_count      = 2'd1;
        if (2 * r + 1 < emitted.size()) begin
          res.out_pair[7:0] = emitted[2 * r + 1];
          res.out_count     = 2'd2;
        end
      end
      if (it.in_last && r == nres - 1) begin
        res.out_last   = 1'b1;
        res.out_status = bad;
      end
      append_expected(res);
    end
    // last byte ends the file, the next byte starts a new one
    if (it.in_last) begin
      clear_walk();
    end
  endtask

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  // sample both channels on the falling edge ahead of the edge that takes the transfer
  always @(negedge clk) begin
    if (rst) begin
      clear_walk();
      expected_pairs.delete();
    end else begin
      if (byte_valid && byte_ready) begin
        predict_pairs(byte_item);
      end
      if (pair_valid && pair_ready) begin
        if (expected_pairs.size() == 0) begin
          note_failure($sformatf("unexpected result pair %h count %0d last %b status %b",
                                 pair_item.out_pair, pair_item.out_count,
                                 pair_item.out_last, pair_item.out_status));
        end else begin
          want = expected_pairs.pop_front();
          if (pair_item.out_pair !== want.out_pair || pair_item.out_count !== want.out_count ||
              pair_item.out_last !== want.out_last ||
              pair_item.out_status !== want.out_status) begin
            note_failure($sformatf(
              "expected pair %h count %0d last %b status %b, got pair %h count %0d last %b status %b",
              want.out_pair, want.out_count, want.out_last, want.out_status,
              pair_item.out_pair, pair_item.out_count, pair_item.out_last,
              pair_item.out_status));
          end
        end
      end
    end
    outstanding = expected_pairs.size();
  end

endmodule

### sim/png_color_chunk_injector_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the png color chunk injector: clock, reset, file stimulus,
// receiver stalls and the verdict; depends on pcci_pkg, the block and
// pcci_stream_checker
module png_color_chunk_injector_unit_tb;
  import pcci_pkg::*;

  localparam int          RANDOM_ITEMS = 170;
  localparam logic [31:0] IHDR_TAG     = 32'h49484452;
  localparam logic [31:0] HUGE_LENGTH  = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  in_item_t    byte_item;
  logic        pair_valid;
  logic        pair_ready;
  out_item_t   pair_item;
  int          failures;
  int          outstanding;

  logic [7:0]  file_bytes [$];
  int          burst_left;
  int          random_items;
  stall_mode_t stall_mode;
  int          stall_phase;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  png_color_chunk_injector_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair_item  (pair_item)
  );

  pcci_stream_checker stream_check (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .pair_valid  (pair_valid),
    .pair_ready  (pair_ready),
    .pair_item   (pair_item),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // receiver stall pattern, with its mode redrawn at random from the stall phase counter
  always @(posedge clk) begin
    if (rst) begin
      pair_ready  <= 1'b0;
      stall_phase <= 0;
      stall_mode  <= STALL_NONE;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 63) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
      end
      case (stall_mode)
        STALL_NONE:     pair_ready <= 1'b1;
        STALL_RANDOM:   pair_ready <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: pair_ready <= ((stall_phase % 5) < 3);
        default:        pair_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one more byte at the end of the file
  task automatic append_file_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic add_be32(input logic [31:0] w);
    for (int j = 0; j < 4; j++) begin
      append_file_byte(w[31 - 8 * j -: 8]);
    end
  endtask

  task automatic add_random(input int count);
    repeat (count) append_file_byte(8'($urandom_range(0, 255)));
  endtask

  // length, tag, random data and a crc field the block never checks
  task automatic add_chunk(input logic [31:0] len, input logic [31:0] tag);
    add_be32(len);
    add_be32(tag);
    add_random(int'(len) + 4);
  endtask

  // send the file in bursts, last flag on its final byte
  task automatic send_file();
    in_item_t item;
    int       gap;
    for (int i = 0; i < file_bytes.size(); i++) begin
      // idle gap between bursts
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          byte_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      item.in_byte = file_bytes[i];
      item.in_last = (i == file_bytes.size() - 1);
      byte_item  <= item;
      byte_valid <= 1'b1;
      // transfer at the first edge where ready is seen high
      @(negedge clk);
      while (!byte_ready) @(negedge clk);
      @(posedge clk);
      burst_left--;
    end
    file_bytes.delete();
  endtask

  initial begin : stimulus
    int          file_kind;
    int          chunk_total;
    int          tail_kind;
    logic [31:0] tag;
    logic [31:0] cut_len;
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_item    = '0;
    pair_ready   = 1'b0;
    stall_mode   = STALL_NONE;
    stall_phase  = 0;
    burst_left   = 0;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // file cut after one byte of the signature
    append_file_byte(8'hFF);
    send_file();
    // file of the signature alone, still too short
    repeat (8) append_file_byte(8'hFF);
    send_file();
    // one byte into the first chunk: dropped, a result with no bytes and status clear
    repeat (9) append_file_byte(8'h00);
    send_file();

    while (random_items < RANDOM_ITEMS) begin
      file_kind = $urandom_range(0, 9);
      if (file_kind < 6) begin
        // well-formed chunks, mostly opened by ihdr, sometimes a second ihdr
        add_random(8);
        chunk_total = $urandom_range(1, 3);
        for (int c = 0; c < chunk_total; c++) begin
          if ((c == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 3) == 0) begin
            tag = IHDR_TAG;
          end else begin
            tag = $urandom;
          end
          add_chunk((c == 0) ? $urandom_range(0, 13) : $urandom_range(0, 6), tag);
        end
        tail_kind = $urandom_range(0, 3);
        if (tail_kind == 1) begin
          // short tail inside the held head
          add_random($urandom_range(1, 11));
        end else if (tail_kind == 2) begin
          // chunk cut after its head has passed
          cut_len = ($urandom_range(0, 2) == 0) ? HUGE_LENGTH : $urandom_range(1, 20);
          add_be32(cut_len);
          add_be32($urandom);
          add_random((cut_len > 32'd7) ? $urandom_range(4, 10)
                                       : $urandom_range(4, int'(cut_len) + 3));
        end
      end else if (file_kind < 8) begin
        // file that ends inside the signature
        add_random($urandom_range(1, 8));
      end else begin
        // noise after the signature, random lengths and tags
        add_random(8 + $urandom_range(1, 24));
      end
      random_items += file_bytes.size();
      send_file();
    end
    byte_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### png_color_chunk_injector_unit.f
+incdir+hdl
hdl/pcci_pkg.sv
hdl/pcci_front.sv
hdl/pcci_job_queue.sv
hdl/pcci_back.sv
hdl/png_color_chunk_injector_unit.sv
sim/pcci_stream_checker.sv
sim/png_color_chunk_injector_unit_tb.sv
